[hdl/bpa_pkg.sv]
// Shared types and codes of the buddy page allocator.
// Used by bpa_ctrl and buddy_page_allocator_top; depends on nothing.
`default_nettype none
package bpa_pkg;

    localparam int FRAME_W = 20;
    localparam int ORDER_W = 4;
    localparam int TOTAL_W = 11;

    localparam logic [1:0] ACT_SEED  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    localparam logic CFG_BASE_FRAME = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] base_frame;
        logic [TOTAL_W-1:0] page_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] result_frame;
    } t_result;

    typedef enum logic [16:0] {
        S_CLR    = 17'b00000000000000001,
        S_IDLE   = 17'b00000000000000010,
        S_DEC    = 17'b00000000000000100,
        S_SEED_R = 17'b00000000000001000,
        S_SRCH   = 17'b00000000000010000,
        S_AL_R   = 17'b00000000000100000,
        S_SPLIT  = 17'b00000000001000000,
        S_SP_R   = 17'b00000000010000000,
        S_AL_END = 17'b00000000100000000,
        S_FREE_R = 17'b00000001000000000,
        S_MRG    = 17'b00000010000000000,
        S_MB_R   = 17'b00000100000000000,
        S_UL     = 17'b00001000000000000,
        S_UL_R   = 17'b00010000000000000,
        S_MCLR   = 17'b00100000000000000,
        S_PUSH   = 17'b01000000000000000,
        S_FIN    = 17'b10000000000000000
    } t_state;

endpackage
`default_nettype wire

[hdl/buddy_page_allocator_top.sv]
// Top level of the buddy page allocator: configuration registers, result register,
// page RAM and sequencer. Depends on bpa_pkg, bpa_ram and bpa_ctrl.
// A seed reads its page entry; an allocate searches the orders upward, then splits one
// order at a time (a blocked split ends it); a free merges one order at a time, walking
// the list of each order to unlink the buddy; a rejected word leaves the lists alone.
// One word is in flight; the next is taken the cycle after its result is registered.
// Reset: all lists empty; a clearing pass over all MAX_PAGES entries zeroes the page RAM
// while no input word is taken (configuration writes are always taken).
`default_nettype none
module buddy_page_allocator_top #(
    parameter int MAX_PAGES = 1024,
    parameter int TOP_ORDER = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // frame[19:0], order[23:20]
    input  wire logic [1:0]  i_s_axis_tuser,  // action[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // result_frame[19:0], zero pad[23:20]
    output logic [1:0]       o_m_axis_tuser   // status[1:0]
);
    // Each page entry holds its free mark, block order and next link, from the top bit down.
    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int IW = $clog2(MAX_PAGES + 1);
    localparam int EW = 1 + bpa_pkg::ORDER_W + IW;

    bpa_pkg::t_cfg    r_cfg;
    bpa_pkg::t_result res;
    bpa_pkg::t_result r_out;
    logic             r_ovalid;
    logic             res_valid;
    logic             res_take;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [EW-1:0]    wdata, rdata;

    // Configuration writes are always accepted; the user must issue them only while the block is idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpa_pkg::CFG_BASE_FRAME: r_cfg.base_frame <= i_cfg_data;
                bpa_pkg::CFG_PAGE_LIMIT: r_cfg.page_limit <= i_cfg_data[10:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // The result register frees the sequencer as soon as a result is handed over.
    assign res_take = res_valid && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'd0, r_out.result_frame};
    assign o_m_axis_tuser  = r_out.status;

    bpa_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_PAGES)
    ) u_page_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    bpa_ctrl #(
        .MAX_PAGES(MAX_PAGES),
        .TOP_ORDER(TOP_ORDER),
        .AW       (AW),
        .EW       (EW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_action   (i_s_axis_tuser),
        .i_frame    (i_s_axis_tdata[19:0]),
        .i_order    (i_s_axis_tdata[23:20]),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );
endmodule
`default_nettype wire

[hdl/bpa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/bpa_ctrl.sv]
// Sequencer of the allocator: list heads, seed, split and merge walks over the page RAM.
// Depends on bpa_pkg; drives the ports of one bpa_ram instance.
`default_nettype none
module bpa_ctrl #(
    parameter int MAX_PAGES = 1024,
    parameter int TOP_ORDER = 10,
    parameter int AW        = 10,
    parameter int EW        = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bpa_pkg::t_cfg               i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_action,
    input  wire logic [bpa_pkg::FRAME_W-1:0] i_frame,
    input  wire logic [bpa_pkg::ORDER_W-1:0] i_order,
    output logic                             o_res_valid,
    input  wire logic                        i_res_take,
    output bpa_pkg::t_result                 o_res,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic [EW-1:0]                    o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  wire logic [EW-1:0]               i_rdata
);
    localparam int IW  = $clog2(MAX_PAGES + 1);
    localparam int LW  = $clog2(TOP_ORDER + 1);
    localparam int RW  = ((AW > 15) ? AW : 15) + 1;
    localparam int FW  = bpa_pkg::FRAME_W;
    localparam int OW  = bpa_pkg::ORDER_W;
    localparam logic [IW-1:0] NO_PAGE = IW'(MAX_PAGES);
    localparam logic [OW-1:0] TOP     = OW'(TOP_ORDER);

    bpa_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_head [0:TOP_ORDER];
    logic [IW-1:0] n_head [0:TOP_ORDER];
    logic [1:0]    r_act, n_act;
    logic [FW-1:0] r_frame, n_frame;
    logic [OW-1:0] r_ord, n_ord;
    logic [OW-1:0] r_lvl, n_lvl;
    logic [AW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_inext, n_inext;
    logic [AW-1:0] r_right, n_right;
    logic [AW-1:0] r_bidx, n_bidx;
    logic [EW-1:0] r_bent, n_bent;
    logic [IW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_prev, n_prev;
    logic [EW-1:0] r_prev_ent, n_prev_ent;
    logic          r_prev_ok, n_prev_ok;
    logic [IW-1:0] r_steps, n_steps;
    logic [AW-1:0] r_clr, n_clr;
    bpa_pkg::t_result r_res, n_res;

    logic [IW-1:0] pc;
    logic [FW-1:0] diff_a, diff_b, idx_frame, bfr;
    logic          ok_a, ok_b;
    logic          rd_free;
    logic [OW-1:0] rd_ord;
    logic [IW-1:0] rd_next;
    logic [RW-1:0] right;
    logic [OW-1:0] dl;
    logic [LW-1:0] lvlx, ordx, dlx;

    // Effective page count and the range checks of the input frame and the buddy frame.
    always_comb begin
        pc = (32'(i_cfg.page_limit) > 32'(MAX_PAGES)) ? NO_PAGE : IW'(i_cfg.page_limit);
        diff_a    = r_frame - i_cfg.base_frame;
        ok_a      = (r_frame >= i_cfg.base_frame) && (32'(diff_a) < 32'(pc));
        idx_frame = i_cfg.base_frame + FW'(r_idx);
        bfr       = idx_frame ^ (FW'(1) << r_ord);
        diff_b    = bfr - i_cfg.base_frame;
        ok_b      = (bfr >= i_cfg.base_frame) && (32'(diff_b) < 32'(pc));
        rd_free   = i_rdata[EW-1];
        rd_ord    = i_rdata[EW-2 -: OW];
        rd_next   = i_rdata[IW-1:0];
        right     = RW'(r_idx) + (RW'(1) << (r_lvl - OW'(1)));
        dl        = r_lvl - OW'(1);
        lvlx      = r_lvl[LW-1:0];
        ordx      = r_ord[LW-1:0];
        dlx       = dl[LW-1:0];
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_act      = r_act;
        n_frame    = r_frame;
        n_ord      = r_ord;
        n_lvl      = r_lvl;
        n_idx      = r_idx;
        n_inext    = r_inext;
        n_right    = r_right;
        n_bidx     = r_bidx;
        n_bent     = r_bent;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_prev_ent = r_prev_ent;
        n_prev_ok  = r_prev_ok;
        n_steps    = r_steps;
        n_clr      = r_clr;
        n_res      = r_res;
        o_we       = 1'b0;
        o_waddr    = r_idx;
        o_wdata    = '0;
        o_raddr    = r_idx;
        case (r_state)
            bpa_pkg::S_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(MAX_PAGES - 1)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_frame = i_frame;
                    n_ord   = i_order;
                    n_state = bpa_pkg::S_DEC;
                end
            end
            bpa_pkg::S_DEC: begin
                n_res.status       = bpa_pkg::ST_INV;
                n_res.result_frame = '0;
                n_state            = bpa_pkg::S_FIN;
                case (r_act)
                    bpa_pkg::ACT_SEED: begin
                        if (ok_a) begin
                            n_idx   = diff_a[AW-1:0];
                            o_raddr = diff_a[AW-1:0];
                            n_state = bpa_pkg::S_SEED_R;
                        end
                    end
                    bpa_pkg::ACT_ALLOC: begin
                        if (r_ord <= TOP) begin
                            n_lvl   = r_ord;
                            n_state = bpa_pkg::S_SRCH;
                        end
                    end
                    bpa_pkg::ACT_FREE: begin
                        if (r_ord <= TOP && ok_a) begin
                            n_idx   = diff_a[AW-1:0];
                            o_raddr = diff_a[AW-1:0];
                            n_state = bpa_pkg::S_FREE_R;
                        end
                    end
                    default: begin
                        n_state = bpa_pkg::S_FIN;
                    end
                endcase
            end
            bpa_pkg::S_SEED_R: begin
                if (rd_free) begin
                    n_res.status = bpa_pkg::ST_INV;
                end else begin
                    o_we         = 1'b1;
                    o_wdata      = {1'b1, OW'(0), r_head[0]};
                    n_head[0]    = IW'(r_idx);
                    n_res.status = bpa_pkg::ST_OK;
                end
                n_res.result_frame = '0;
                n_state = bpa_pkg::S_FIN;
            end
            bpa_pkg::S_SRCH: begin
                if (r_head[lvlx] < NO_PAGE) begin
                    n_idx   = r_head[lvlx][AW-1:0];
                    o_raddr = r_head[lvlx][AW-1:0];
                    n_state = bpa_pkg::S_AL_R;
                end else if (r_lvl == TOP) begin
                    n_res.status       = bpa_pkg::ST_OOM;
                    n_res.result_frame = '0;
                    n_state            = bpa_pkg::S_FIN;
                end else begin
                    n_lvl = r_lvl + OW'(1);
                end
            end
            bpa_pkg::S_AL_R: begin
                // Pop the head; the split starts from the block's own order.
                n_head[lvlx] = rd_next;
                n_inext      = rd_next;
                n_lvl        = (rd_ord > TOP) ? TOP : rd_ord;
                n_state      = bpa_pkg::S_SPLIT;
            end
            bpa_pkg::S_SPLIT: begin
                n_state = bpa_pkg::S_AL_END;
                if (r_lvl > r_ord) begin
                    if (right < RW'(pc) && right < RW'(MAX_PAGES)) begin
                        n_right = right[AW-1:0];
                        o_raddr = right[AW-1:0];
                        n_state = bpa_pkg::S_SP_R;
                    end
                end
            end
            bpa_pkg::S_SP_R: begin
                if (rd_free) begin
                    n_state = bpa_pkg::S_AL_END;
                end else begin
                    o_we        = 1'b1;
                    o_waddr     = r_right;
                    o_wdata     = {1'b1, dl, r_head[dlx]};
                    n_head[dlx] = IW'(r_right);
                    n_lvl       = dl;
                    n_state     = bpa_pkg::S_SPLIT;
                end
            end
            bpa_pkg::S_AL_END: begin
                o_we               = 1'b1;
                o_wdata            = {1'b0, r_lvl, r_inext};
                n_res.status       = bpa_pkg::ST_OK;
                n_res.result_frame = idx_frame;
                n_state            = bpa_pkg::S_FIN;
            end
            bpa_pkg::S_FREE_R: begin
                if (rd_free) begin
                    n_res.status       = bpa_pkg::ST_INV;
                    n_res.result_frame = '0;
                    n_state            = bpa_pkg::S_FIN;
                end else begin
                    n_state = bpa_pkg::S_MRG;
                end
            end
            bpa_pkg::S_MRG: begin
                n_state = bpa_pkg::S_PUSH;
                if (r_ord < TOP && ok_b) begin
                    n_bidx  = diff_b[AW-1:0];
                    o_raddr = diff_b[AW-1:0];
                    n_state = bpa_pkg::S_MB_R;
                end
            end
            bpa_pkg::S_MB_R: begin
                if (!rd_free || rd_ord != r_ord) begin
                    n_state = bpa_pkg::S_PUSH;
                end else begin
                    n_bent    = i_rdata;
                    n_cur     = r_head[ordx];
                    n_prev_ok = 1'b0;
                    n_steps   = '0;
                    n_state   = bpa_pkg::S_UL;
                end
            end
            bpa_pkg::S_UL: begin
                // Walk the list of this order until the buddy is found, then unlink it.
                if (r_cur < NO_PAGE && r_steps < NO_PAGE) begin
                    if (r_cur == IW'(r_bidx)) begin
                        if (r_prev_ok) begin
                            o_we    = 1'b1;
                            o_waddr = r_prev;
                            o_wdata = {r_prev_ent[EW-1:IW], r_bent[IW-1:0]};
                        end else begin
                            n_head[ordx] = r_bent[IW-1:0];
                        end
                        n_state = bpa_pkg::S_MCLR;
                    end else begin
                        o_raddr = r_cur[AW-1:0];
                        n_state = bpa_pkg::S_UL_R;
                    end
                end else begin
                    n_state = bpa_pkg::S_PUSH;
                end
            end
            bpa_pkg::S_UL_R: begin
                n_prev     = r_cur[AW-1:0];
                n_prev_ent = i_rdata;
                n_prev_ok  = 1'b1;
                n_cur      = rd_next;
                n_steps    = r_steps + IW'(1);
                n_state    = bpa_pkg::S_UL;
            end
            bpa_pkg::S_MCLR: begin
                o_we    = 1'b1;
                o_waddr = r_bidx;
                o_wdata = {1'b0, r_bent[EW-2:0]};
                if (r_bidx < r_idx) begin
                    n_idx = r_bidx;
                end
                n_ord   = r_ord + OW'(1);
                n_state = bpa_pkg::S_MRG;
            end
            bpa_pkg::S_PUSH: begin
                o_we               = 1'b1;
                o_wdata            = {1'b1, r_ord, r_head[ordx]};
                n_head[ordx]       = IW'(r_idx);
                n_res.status       = bpa_pkg::ST_OK;
                n_res.result_frame = '0;
                n_state            = bpa_pkg::S_FIN;
            end
            bpa_pkg::S_FIN: begin
                if (i_res_take) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLR;
            r_clr   <= '0;
            for (int k = 0; k <= TOP_ORDER; k++) begin
                r_head[k] <= NO_PAGE;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_frame    <= n_frame;
        r_ord      <= n_ord;
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_inext    <= n_inext;
        r_right    <= n_right;
        r_bidx     <= n_bidx;
        r_bent     <= n_bent;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_ent <= n_prev_ent;
        r_prev_ok  <= n_prev_ok;
        r_steps    <= n_steps;
        r_res      <= n_res;
    end

    assign o_in_ready  = (r_state == bpa_pkg::S_IDLE);
    assign o_res_valid = (r_state == bpa_pkg::S_FIN);
    assign o_res       = r_res;
endmodule
`default_nettype wire

[tb/tb_buddy_page_allocator_top.sv]
// Self-checking testbench for buddy_page_allocator_top: seeds, allocates and frees
// page blocks over a stream interface and checks every result word against a
// built-in buddy allocator. Depends on bpa_pkg and the RTL only.
`timescale 1ns / 100ps
module tb_buddy_page_allocator_top;

    localparam int MAX_PAGES  = 1024;
    localparam int TOP_ORDER  = 10;
    localparam int PLAN       = 0;  // allocator copy used while generating requests
    localparam int CHK        = 1;  // allocator copy advanced at each accepted word
    localparam int unsigned FRAME_MASK = 32'hFFFFF;
    localparam logic [1:0]  ACT_UNDEF  = 2'd3;  // action code with no meaning
    localparam logic [15:0] STALL_PAT  = 16'b1011_0011_1101_0110;

    typedef struct {
        logic [1:0]                  act;
        logic [bpa_pkg::FRAME_W-1:0] frame;
        logic [bpa_pkg::ORDER_W-1:0] ord;
    } t_page_req;

    typedef struct {
        logic [bpa_pkg::FRAME_W-1:0] frame;
        int unsigned                 ord;
    } t_held_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_data = '0;
    logic        tx_valid = 1'b0;
    logic [23:0] tx_data = '0;
    logic [1:0]  tx_user = '0;
    logic        rx_ready = 1'b0;
    logic        o_cfg_ready, o_s_axis_tready, o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    buddy_page_allocator_top #(.MAX_PAGES(MAX_PAGES), .TOP_ORDER(TOP_ORDER)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (tx_data),    // frame[19:0], order[23:20]
        .i_s_axis_tuser  (tx_user),    // action[1:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // result_frame[19:0], zero pad[23:20]
        .o_m_axis_tuser  (o_m_axis_tuser)   // status[1:0]
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two copies of the allocator state: one is run ahead by the request
    // generator so it knows which blocks it holds, the other is advanced only
    // when the block actually takes a word and produces the expected results.
    int unsigned base_r [2];
    int unsigned pages_r [2];
    int unsigned head_r [2][TOP_ORDER+1];
    int unsigned next_r [2][MAX_PAGES];
    int unsigned ord_r [2][MAX_PAGES];
    bit          fm_r [2][MAX_PAGES];

    t_page_req        pend_q [$];
    bpa_pkg::t_result expect_q [$];
    t_held_block      held_q [$];
    t_page_req        cur_req;

    int n_err = 0, n_acc = 0, n_res = 0;
    int n_status [4] = '{0, 0, 0, 0};
    int burst_left = 0, gap_left = 0;
    int hold_cnt = 0;
    bit hold_done = 0;
    int unsigned rx_cyc = 0;

    function automatic int unsigned eff_pages(int m);
        return (pages_r[m] > MAX_PAGES) ? MAX_PAGES : pages_r[m];
    endfunction

    function automatic bit to_page(int m, int unsigned fr, output int unsigned idx);
        idx = 0;
        if (fr < base_r[m]) return 0;
        if (fr - base_r[m] >= eff_pages(m)) return 0;
        idx = fr - base_r[m];
        return 1;
    endfunction

    function automatic void push_free(int m, int unsigned o, int unsigned idx);
        ord_r[m][idx]  = o;
        fm_r[m][idx]   = 1;
        next_r[m][idx] = head_r[m][o];
        head_r[m][o]   = idx;
    endfunction

    function automatic bit unlink_free(int m, int unsigned o, int unsigned idx);
        int unsigned prev, cur, steps;
        prev  = MAX_PAGES;
        cur   = head_r[m][o];
        steps = 0;
        while (cur < MAX_PAGES && steps < MAX_PAGES) begin
            if (cur == idx) begin
                if (prev == MAX_PAGES) head_r[m][o] = next_r[m][cur];
                else next_r[m][prev] = next_r[m][cur];
                return 1;
            end
            prev = cur;
            cur  = next_r[m][cur];
            steps++;
        end
        return 0;
    endfunction

    function automatic void clear_alloc(int m);
        base_r[m]  = 0;
        pages_r[m] = 0;
        for (int i = 0; i <= TOP_ORDER; i++) head_r[m][i] = MAX_PAGES;
        for (int i = 0; i < MAX_PAGES; i++) begin
            next_r[m][i] = 0;
            ord_r[m][i]  = 0;
            fm_r[m][i]   = 0;
        end
    endfunction

    // One request applied to allocator copy m; returns the result word.
    function automatic bpa_pkg::t_result apply_req(int m, t_page_req q);
        bpa_pkg::t_result r;
        int unsigned      idx, bidx, lvl, right, bfr;
        r.status = bpa_pkg::ST_INV;
        r.result_frame = '0;
        case (q.act)
            bpa_pkg::ACT_SEED: begin
                if (to_page(m, q.frame, idx) && !fm_r[m][idx]) begin
                    push_free(m, 0, idx);
                    r.status = bpa_pkg::ST_OK;
                end
            end
            bpa_pkg::ACT_ALLOC: begin
                if (q.ord <= TOP_ORDER) begin
                    idx = MAX_PAGES;
                    for (lvl = q.ord; lvl <= TOP_ORDER; lvl++) begin
                        if (head_r[m][lvl] < MAX_PAGES) begin
                            idx = head_r[m][lvl];
                            head_r[m][lvl] = next_r[m][idx];
                            break;
                        end
                    end
                    if (idx == MAX_PAGES) begin
                        r.status = bpa_pkg::ST_OOM;
                    end else begin
                        // Split from the fetched block's own order, not the request's.
                        fm_r[m][idx] = 0;
                        lvl = ord_r[m][idx];
                        if (lvl > TOP_ORDER) lvl = TOP_ORDER;
                        while (lvl > q.ord) begin
                            right = idx + (1 << (lvl - 1));
                            if (right >= eff_pages(m) || right >= MAX_PAGES || fm_r[m][right])
                                break;
                            lvl--;
                            push_free(m, lvl, right);
                        end
                        ord_r[m][idx] = lvl;
                        r.status = bpa_pkg::ST_OK;
                        r.result_frame = bpa_pkg::FRAME_W'((base_r[m] + idx) & FRAME_MASK);
                    end
                end
            end
            bpa_pkg::ACT_FREE: begin
                if (q.ord <= TOP_ORDER && to_page(m, q.frame, idx) && !fm_r[m][idx]) begin
                    lvl = q.ord;
                    while (lvl < TOP_ORDER) begin
                        bfr = (base_r[m] + idx) ^ (1 << lvl);
                        if (!to_page(m, bfr, bidx)) break;
                        if (!fm_r[m][bidx] || ord_r[m][bidx] != lvl) break;
                        if (!unlink_free(m, lvl, bidx)) break;
                        fm_r[m][bidx] = 0;
                        fm_r[m][idx]  = 0;
                        if (bidx < idx) idx = bidx;
                        lvl++;
                    end
                    push_free(m, lvl, idx);
                    r.status = bpa_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch at result word %0d: %s is 0x%0h, expected 0x%0h",
                 n_res, what, got, want);
        n_err++;
    endtask

    // Queues one request and tracks the blocks it hands out.
    task automatic send_req(logic [1:0] act, int unsigned fr, int unsigned ord);
        t_page_req        q;
        bpa_pkg::t_result r;
        t_held_block      h;
        q.act   = act;
        q.frame = fr[bpa_pkg::FRAME_W-1:0];
        q.ord   = ord[bpa_pkg::ORDER_W-1:0];
        r = apply_req(PLAN, q);
        pend_q.push_back(q);
        if (act == bpa_pkg::ACT_ALLOC && r.status == bpa_pkg::ST_OK) begin
            h.frame = r.result_frame;
            h.ord   = ord_r[PLAN][(r.result_frame - base_r[PLAN]) & FRAME_MASK];
            held_q.push_back(h);
        end
    endtask

    // Mostly well-formed traffic: allocations, frees of held blocks and seeds
    // near the managed range, with some wrong orders, unaligned frees and noise.
    task automatic random_req(int unsigned ord_hi);
        int unsigned r, k, fr, o;
        t_held_block h;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, ord_hi);
            send_req(bpa_pkg::ACT_ALLOC, $urandom, o);
        end else if (r < 78 && held_q.size() > 0) begin
            k = $urandom_range(0, held_q.size() - 1);
            h = held_q[k];
            held_q.delete(k);
            o  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : h.ord;
            fr = ($urandom_range(0, 15) == 0) ? (h.frame ^ 1) : h.frame;
            send_req(bpa_pkg::ACT_FREE, fr, o);
        end else if (r < 90) begin
            send_req(bpa_pkg::ACT_SEED, base_r[PLAN] + $urandom_range(0, eff_pages(PLAN)), 0);
        end else begin
            send_req(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 15));
        end
    endtask

    // Waits until every word has been taken and answered, then lets the block settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || tx_valid || expect_q.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[19:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        for (int m = 0; m < 2; m++) begin
            if (idx == bpa_pkg::CFG_BASE_FRAME) base_r[m] = val & FRAME_MASK;
            else pages_r[m] = val & 32'h7FF;
        end
    endtask

    // Sender: bursts of random length separated by random gaps. The expected
    // result is worked out at the edge where the block takes the word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && o_s_axis_tready) begin
                expect_q.push_back(apply_req(CHK, cur_req));
                n_acc++;
            end
            if (!tx_valid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tx_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_req = pend_q.pop_front();
                    tx_data <= {cur_req.ord, cur_req.frame};
                    tx_user <= cur_req.act;
                    tx_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: cycles through always-ready, a fixed stall pattern and random
    // stalls. Once, a long hold-off lets results back up into the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            rx_cyc++;
            if (!hold_done && n_res >= 300) begin
                hold_done = 1;
                hold_cnt  = 800;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rx_ready <= 1'b0;
            end else begin
                case (rx_cyc[9:8])
                    2'd0:    rx_ready <= 1'b1;
                    2'd1:    rx_ready <= STALL_PAT[rx_cyc[3:0]];
                    default: rx_ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    // Result checker: every word is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && rx_ready) begin
            if (expect_q.size() == 0) begin
                report_mismatch("unexpected word, status", o_m_axis_tuser, 0);
            end else begin
                bpa_pkg::t_result want;
                want = expect_q.pop_front();
                if (o_m_axis_tuser != want.status)
                    report_mismatch("status", o_m_axis_tuser, want.status);
                if (o_m_axis_tdata[19:0] != want.result_frame)
                    report_mismatch("result_frame", o_m_axis_tdata[19:0], want.result_frame);
            end
            n_status[o_m_axis_tuser]++;
            n_res++;
        end
    end

    // Stimulus phases; registers change only while the block is idle.
    initial begin
        clear_alloc(PLAN);
        clear_alloc(CHK);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing managed yet: every request fails.
        send_req(bpa_pkg::ACT_ALLOC, 0, 0);
        send_req(bpa_pkg::ACT_ALLOC, 0, 15);
        send_req(bpa_pkg::ACT_SEED, 0, 0);
        send_req(bpa_pkg::ACT_FREE, 0, 0);
        send_req(ACT_UNDEF, 20'hFFFFF, 15);
        wait_idle();

        // Small pool just above frame 0x100, edges and error cases first.
        write_reg(bpa_pkg::CFG_BASE_FRAME, 32'h100);
        write_reg(bpa_pkg::CFG_PAGE_LIMIT, 64);
        send_req(bpa_pkg::ACT_SEED, 32'h100, 0);
        send_req(bpa_pkg::ACT_SEED, 32'h13F, 15);
        send_req(bpa_pkg::ACT_SEED, 32'h0FF, 0);
        send_req(bpa_pkg::ACT_SEED, 32'h140, 0);
        send_req(bpa_pkg::ACT_SEED, 32'h100, 0);
        send_req(bpa_pkg::ACT_ALLOC, 0, 11);
        send_req(bpa_pkg::ACT_ALLOC, 32'hFFFFF, TOP_ORDER);
        send_req(bpa_pkg::ACT_FREE, 32'h13F, 15);
        send_req(bpa_pkg::ACT_FREE, 32'h100, 0);
        send_req(bpa_pkg::ACT_FREE, 32'h13F, 0);
        send_req(bpa_pkg::ACT_ALLOC, 0, 0);
        send_req(bpa_pkg::ACT_ALLOC, 0, 0);
        send_req(bpa_pkg::ACT_ALLOC, 0, 0);
        for (int i = 1; i < 63; i++) send_req(bpa_pkg::ACT_SEED, 32'h100 + i, 0);
        // Return pages one at a time so buddies merge into large blocks.
        for (int i = 0; i < 64; i++) send_req(bpa_pkg::ACT_ALLOC, 0, 0);
        while (held_q.size() > 0) begin
            t_held_block h;
            h = held_q.pop_front();
            send_req(bpa_pkg::ACT_FREE, h.frame, h.ord);
        end
        for (int i = 0; i < 300; i++) random_req(6);
        wait_idle();

        // Top of the frame space; a page count above the limit acts as the limit.
        held_q.delete();
        write_reg(bpa_pkg::CFG_BASE_FRAME, 32'hFFFC0);
        write_reg(bpa_pkg::CFG_PAGE_LIMIT, 2047);
        for (int i = 0; i < 64; i++) send_req(bpa_pkg::ACT_SEED, 32'hFFFC0 + i, 0);
        for (int i = 0; i < 250; i++) random_req(6);
        wait_idle();

        // Full page range from frame 0.
        held_q.delete();
        write_reg(bpa_pkg::CFG_BASE_FRAME, 0);
        write_reg(bpa_pkg::CFG_PAGE_LIMIT, MAX_PAGES);
        for (int i = 0; i < 200; i++)
            send_req(bpa_pkg::ACT_SEED, $urandom_range(0, MAX_PAGES - 1), 0);
        for (int i = 0; i < 400; i++) random_req(TOP_ORDER);
        wait_idle();

        // Lowered page count: blocks already listed beyond it stay allocatable.
        write_reg(bpa_pkg::CFG_PAGE_LIMIT, 16);
        for (int i = 0; i < 150; i++) random_req(4);
        wait_idle();

        // Highest base with no pages.
        write_reg(bpa_pkg::CFG_BASE_FRAME, 32'hFFFFF);
        write_reg(bpa_pkg::CFG_PAGE_LIMIT, 0);
        for (int i = 0; i < 40; i++) random_req(TOP_ORDER);
        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("%0d request words taken, %0d result words checked", n_acc, n_res);
        $display("status ok %0d, out of memory %0d, invalid %0d, mismatches %0d",
                 n_status[bpa_pkg::ST_OK], n_status[bpa_pkg::ST_OOM],
                 n_status[bpa_pkg::ST_INV], n_err);
        if (n_err == 0 && expect_q.size() == 0) begin
            $display("** buddy_page_allocator_top: PASSED **");
        end else begin
            $display("** buddy_page_allocator_top: FAILED **");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #400_000_000;
        $display("timeout with %0d results outstanding", expect_q.size());
        $display("** buddy_page_allocator_top: FAILED **");
        $finish;
    end

endmodule
